// ----- design/dtm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and lookup tables for the date text to MJD parser.
// Used by every module of the block but dtm_queue; depends on nothing else.
package dtm_pkg;

   // Configuration defaults and fixed field widths.
   localparam int QUEUE_DEPTH_DEF = 8;
   localparam int MONTH_NAME_MAX  = 9;
   localparam int YEAR_W          = 14;
   localparam int DAY_W           = 6;
   localparam int MJD_W           = 23;
   localparam int CAND_W          = 12;

   localparam logic [YEAR_W-1:0] YEAR_MAX   = 14'd9999;
   localparam logic [DAY_W-1:0]  DAY_MAX    = 6'd63;
   localparam logic [23:0]       MJD_OFFSET = 24'd678576;

   // Character codes that the parser recognizes.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_Z  = 8'h7A;
   localparam logic [7:0] CASE_MASK = 8'hDF;

   // Month index of February, which takes the leap day.
   localparam logic [3:0] MON_FEB = 4'd1;

   // Status codes of a result.
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_NO_YEAR   = 3'd2,
      ST_NO_MONTH  = 3'd3,
      ST_BAD_MONTH = 3'd4,
      ST_BIG_DAY   = 3'd5,
      ST_BIG_YEAR  = 3'd6
   } status_type;

   // One finished text as handed from the front end to the date math.
   typedef struct packed {
      status_type          status;
      logic [YEAR_W-1:0]   year;
      logic [CAND_W-1:0]   cands;
      logic [DAY_W-1:0]    day;
   } job_type;

   // One result as held in the output queue.
   typedef struct packed {
      logic [MJD_W-1:0] mjd;
      status_type       status;
   } result_type;

   // Character of a month name at a position, zero past the end of the name.
   function automatic logic [7:0] month_char(input logic [3:0] mon, input logic [3:0] pos);
      logic [127:0] name;
      int           idx;
      case (mon)
         4'd0:    name = {"JANUARY",   72'd0};
         4'd1:    name = {"FEBRUARY",  64'd0};
         4'd2:    name = {"MARCH",     88'd0};
         4'd3:    name = {"APRIL",     88'd0};
         4'd4:    name = {"MAY",      104'd0};
         4'd5:    name = {"JUNE",      96'd0};
         4'd6:    name = {"JULY",      96'd0};
         4'd7:    name = {"AUGUST",    80'd0};
         4'd8:    name = {"SEPTEMBER", 56'd0};
         4'd9:    name = {"OCTOBER",   72'd0};
         4'd10:   name = {"NOVEMBER",  64'd0};
         4'd11:   name = {"DECEMBER",  64'd0};
         default: name = '0;
      endcase
      idx = 127 - 8 * int'(pos);
      return name[idx -: 8];
   endfunction

   // Days in each month of a common year.
   function automatic logic [4:0] month_len(input logic [3:0] mon);
      logic [4:0] len;
      case (mon)
         4'd1:                      len = 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

   // Days of a common year before the first of each month.
   function automatic logic [8:0] month_start(input logic [3:0] mon);
      logic [8:0] days;
      case (mon)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd59;
         4'd3:    days = 9'd90;
         4'd4:    days = 9'd120;
         4'd5:    days = 9'd151;
         4'd6:    days = 9'd181;
         4'd7:    days = 9'd212;
         4'd8:    days = 9'd243;
         4'd9:    days = 9'd273;
         4'd10:   days = 9'd304;
         default: days = 9'd334;
      endcase
      return days;
   endfunction

endpackage

// ----- design/dtm_queue.sv -----
`timescale 1ns / 1ps
// Small register based first-in first-out queue with a show-ahead output.
// Generic; depends on nothing else.
module dtm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           data_in,
   input  logic                       pop,
   output logic [WIDTH-1:0]           data_out,
   output logic                       full,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign data_out = entries_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and fill count updates, wrapping at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; the fill count guards it.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

// ----- design/dtm_front.sv -----
`timescale 1ns / 1ps
// Byte-wise text parser: year digits, month letters and day digits.
// Depends on dtm_pkg; hands one job per finished text to the back end.
module dtm_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [7:0]      text_byte,
   input  logic            first_byte,
   output logic            job_push,
   output dtm_pkg::job_type job
);

   import dtm_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SKIP,
      PH_YEAR,
      PH_MONTH,
      PH_DAY
   } phase_type;

   phase_type           phase_ff, phase_in, phase_cur;
   logic [YEAR_W-1:0]   year_ff, year_in, year_cur;
   logic                ovf_ff, ovf_in, ovf_cur;
   logic [CAND_W-1:0]   cand_ff, cand_in, cand_cur, cand_letter;
   logic [3:0]          cnt_ff, cnt_in, cnt_cur, cnt_next;
   logic [DAY_W-1:0]    day_ff, day_in, day_cur;
   logic                is_digit, is_alpha;
   logic [3:0]          digit;
   logic [7:0]          upper;
   logic [16:0]         year_prod;
   logic [9:0]          day_prod;
   status_type          code;
   logic                emit;

   // Character classes of the incoming byte.
   assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
   assign is_alpha = ((text_byte >= CH_UP_A) && (text_byte <= CH_UP_Z)) ||
                     ((text_byte >= CH_LO_A) && (text_byte <= CH_LO_Z));
   assign digit    = text_byte[3:0];
   assign upper    = ((text_byte >= CH_LO_A) && (text_byte <= CH_LO_Z)) ?
                     (text_byte & CASE_MASK) : text_byte;

   // A first byte restarts the parse from cleared state.
   assign phase_cur = first_byte ? PH_SKIP : phase_ff;
   assign year_cur  = first_byte ? '0 : year_ff;
   assign ovf_cur   = first_byte ? 1'b0 : ovf_ff;
   assign cand_cur  = first_byte ? '1 : cand_ff;
   assign cnt_cur   = first_byte ? '0 : cnt_ff;
   assign day_cur   = first_byte ? '0 : day_ff;

   // Month candidates that survive this letter at the current position.
   always_comb begin
      for (int m = 0; m < CAND_W; m++) begin
         cand_letter[m] = cand_cur[m] && (int'(cnt_cur) < MONTH_NAME_MAX) &&
                          (month_char(4'(m), cnt_cur) == upper);
      end
   end

   assign cnt_next  = (cnt_cur == 4'hF) ? cnt_cur : cnt_cur + 4'd1;
   assign year_prod = 17'(year_cur) * 17'd10 + 17'(digit);
   assign day_prod  = 10'(day_cur) * 10'd10 + 10'(digit);

   // Parse step for one byte.
   always_comb begin
      phase_in = phase_cur;
      year_in  = year_cur;
      ovf_in   = ovf_cur;
      cand_in  = cand_cur;
      cnt_in   = cnt_cur;
      day_in   = day_cur;
      code     = ST_OK;
      emit     = 1'b0;
      unique case (phase_cur)
         PH_SKIP: begin
            if (text_byte == CH_SPACE || text_byte == CH_TAB) begin
               phase_in = PH_SKIP;
            end else if (text_byte == CH_NUL) begin
               emit = 1'b1;
               code = ST_EMPTY;
            end else if (!is_digit) begin
               emit = 1'b1;
               code = ST_NO_YEAR;
            end else begin
               year_in  = YEAR_W'(digit);
               phase_in = PH_YEAR;
            end
         end
         PH_YEAR: begin
            if (is_digit) begin
               if (year_prod > 17'(YEAR_MAX)) begin
                  year_in = YEAR_MAX;
                  ovf_in  = 1'b1;
               end else begin
                  year_in = year_prod[YEAR_W-1:0];
               end
            end else if (ovf_cur) begin
               emit = 1'b1;
               code = ST_BIG_YEAR;
            end else if (!is_alpha) begin
               emit = 1'b1;
               code = ST_NO_MONTH;
            end else begin
               cand_in  = cand_letter;
               cnt_in   = cnt_next;
               phase_in = PH_MONTH;
            end
         end
         PH_MONTH: begin
            if (is_alpha) begin
               cand_in = cand_letter;
               cnt_in  = cnt_next;
            end else if (is_digit) begin
               day_in   = DAY_W'(digit);
               phase_in = PH_DAY;
            end else begin
               emit = 1'b1;
            end
         end
         PH_DAY: begin
            if (is_digit) begin
               day_in = (day_prod > 10'(DAY_MAX)) ? DAY_MAX : day_prod[DAY_W-1:0];
            end else begin
               emit = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      if (emit) begin
         phase_in = PH_IDLE;
      end
   end

   // The finished text goes out with the state it had before this byte.
   assign job_push   = accept && emit;
   assign job.status = code;
   assign job.year   = year_cur;
   assign job.cands  = cand_cur;
   assign job.day    = day_cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         year_ff  <= '0;
         ovf_ff   <= 1'b0;
         cand_ff  <= '1;
         cnt_ff   <= '0;
         day_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         year_ff  <= year_in;
         ovf_ff   <= ovf_in;
         cand_ff  <= cand_in;
         cnt_ff   <= cnt_in;
         day_ff   <= day_in;
      end
   end

endmodule

// ----- design/dtm_back.sv -----
`timescale 1ns / 1ps
// Date math back end: month and day checks, leap years and the MJD sum.
// Depends on dtm_pkg and dtm_queue; three pipeline stages feed the result queue.
module dtm_back #(
   parameter int QUEUE_DEPTH = dtm_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   input  dtm_pkg::job_type              job,
   output logic                          job_pop,
   input  logic                          rsp_pop,
   output logic                          rsp_empty,
   output logic [dtm_pkg::MJD_W-1:0]     mjd_value,
   output dtm_pkg::status_type           status
);

   import dtm_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH+1);

   // Stage 1: month decode and year mapping.
   logic                s1_valid_ff;
   status_type          s1_status_ff, s1_status_in;
   logic [YEAR_W-1:0]   s1_yr_ff, s1_yr_in;
   logic [3:0]          s1_imon_ff, s1_imon_in;
   logic [DAY_W-1:0]    s1_day_ff;

   // Stage 2: constant products and divisions by one hundred.
   logic                s2_valid_ff;
   status_type          s2_status_ff;
   logic [YEAR_W-1:0]   s2_yr_ff, s2_y_ff;
   logic [21:0]         s2_y365_ff;
   logic [6:0]          s2_qy_ff, s2_qyr_ff;
   logic [3:0]          s2_imon_ff;
   logic [DAY_W-1:0]    s2_day_ff;
   logic [YEAR_W-1:0]   y_in;
   logic [26:0]         qy_prod, qyr_prod;

   // Stage 3: leap year, day check and the year part of the sum.
   logic                s3_valid_ff;
   status_type          s3_status_ff, s3_status_in;
   logic [21:0]         s3_part_ff, s3_part_in;
   logic                s3_leapadj_ff;
   logic [3:0]          s3_imon_ff;
   logic [DAY_W-1:0]    s3_day_ff;
   logic                div100, leap;
   logic [DAY_W-1:0]    day_lim;

   // Result assembly and output queue.
   logic [23:0]         jd;
   result_type          res_in, res_out;
   logic [CW-1:0]       out_count;
   logic [CW:0]         in_use;
   logic                out_full;

   // Take a job only when the result queue has room for everything in flight.
   assign in_use  = (CW+1)'(out_count) + (CW+1)'(s1_valid_ff) +
                    (CW+1)'(s2_valid_ff) + (CW+1)'(s3_valid_ff);
   assign job_pop = job_valid && (in_use < (CW+1)'(QUEUE_DEPTH));

   // Stage 1 logic: exactly one month must remain; two-digit years are widened.
   always_comb begin
      s1_imon_in = '0;
      for (int m = 0; m < CAND_W; m++) begin
         if (job.cands[m]) begin
            s1_imon_in = 4'(m);
         end
      end
      s1_status_in = job.status;
      if (job.status == ST_OK && !$onehot(job.cands)) begin
         s1_status_in = ST_BAD_MONTH;
      end
      if (job.year < 14'd50) begin
         s1_yr_in = job.year + 14'd2000;
      end else if (job.year < 14'd100) begin
         s1_yr_in = job.year + 14'd1900;
      end else begin
         s1_yr_in = job.year;
      end
   end

   // Stage 2 logic: quotients by one hundred through a reciprocal product.
   assign y_in     = s1_yr_ff - 14'd1;
   assign qy_prod  = 27'(y_in) * 27'd5243;
   assign qyr_prod = 27'(s1_yr_ff) * 27'd5243;

   // Stage 3 logic: Gregorian leap rule and the day limit of the month.
   always_comb begin
      div100  = (s2_yr_ff == 14'(s2_qyr_ff) * 14'd100);
      leap    = (s2_yr_ff[1:0] == 2'b00) && (!div100 || s2_qyr_ff[1:0] == 2'b00);
      day_lim = DAY_W'(month_len(s2_imon_ff)) +
                DAY_W'(leap && (s2_imon_ff == MON_FEB));
      s3_status_in = s2_status_ff;
      if (s2_status_ff == ST_OK && s2_day_ff > day_lim) begin
         s3_status_in = ST_BIG_DAY;
      end
      s3_part_in = s2_y365_ff + 22'(s2_y_ff >> 2) - 22'(s2_qy_ff) + 22'(s2_qy_ff >> 2);
   end

   // Final sum; an error result carries a zero date.
   assign jd = 24'(s3_part_ff) + 24'(month_start(s3_imon_ff)) + 24'(s3_leapadj_ff) +
               24'(s3_day_ff) - MJD_OFFSET;
   assign res_in.mjd    = (s3_status_ff == ST_OK) ? jd[MJD_W-1:0] : '0;
   assign res_in.status = s3_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= job_pop;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Pipeline payload needs no reset.
   always_ff @(posedge clock) begin
      s1_status_ff  <= s1_status_in;
      s1_yr_ff      <= s1_yr_in;
      s1_imon_ff    <= s1_imon_in;
      s1_day_ff     <= job.day;
      s2_status_ff  <= s1_status_ff;
      s2_yr_ff      <= s1_yr_ff;
      s2_y_ff       <= y_in;
      s2_y365_ff    <= 22'(y_in) * 22'd365;
      s2_qy_ff      <= qy_prod[25:19];
      s2_qyr_ff     <= qyr_prod[25:19];
      s2_imon_ff    <= s1_imon_ff;
      s2_day_ff     <= s1_day_ff;
      s3_status_ff  <= s3_status_in;
      s3_part_ff    <= s3_part_in;
      s3_leapadj_ff <= leap && (s2_imon_ff > MON_FEB);
      s3_imon_ff    <= s2_imon_ff;
      s3_day_ff     <= s2_day_ff;
   end

   // Results wait here until the receiver pops them.
   dtm_queue #(
      .WIDTH ($bits(result_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_out_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (s3_valid_ff),
      .data_in  (res_in),
      .pop      (rsp_pop),
      .data_out (res_out),
      .full     (out_full),
      .empty    (rsp_empty),
      .count    (out_count)
   );

   assign mjd_value = res_out.mjd;
   // The credit check keeps the queue from filling past what is in flight.
   assign status    = out_full ? res_out.status : res_out.status;

endmodule

// ----- design/date_text_to_mjd_parser_core.sv -----
`timescale 1ns / 1ps
// Top level of the date text to Modified Julian Date parser.
// Depends on dtm_pkg, dtm_queue, dtm_front and dtm_back.
//
// Usage:
//   Request channel: drive req_text_byte and req_first_byte with req_push;
//   a byte is taken at a clock edge where req_push is high and req_full low.
//   req_first_byte marks the first byte of a new date text, which drops any
//   text still being parsed. The byte that ends a text (NUL or any byte that
//   does not fit) produces one result; an error may end a text earlier.
//   Result channel: while rsp_empty is low the oldest result is on
//   rsp_mjd_value and rsp_status; rsp_pop takes it at a clock edge.
//   Throughput: one byte per cycle while req_full is low. A result passes
//   from the byte that ends its text through the job queue, the three math
//   stages and the result queue, each of them registered.
//   The block keeps accepting bytes while results wait; once the result
//   queue and the job queue (QUEUE_DEPTH entries each) fill up behind a
//   stalled receiver, req_full rises until results are popped.
//   Reset: synchronous and active high; it empties both queues and puts the
//   parser in its idle state, where bytes without req_first_byte are ignored.
module date_text_to_mjd_parser_core #(
   parameter int QUEUE_DEPTH = dtm_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [7:0]                        req_text_byte,
   input  logic                              req_first_byte,
   input  logic                              req_push,
   output logic                              req_full,
   output logic signed [dtm_pkg::MJD_W-1:0]  rsp_mjd_value,
   output logic [2:0]                        rsp_status,
   output logic                              rsp_empty,
   input  logic                              rsp_pop
);

   import dtm_pkg::*;

   logic                        accept;
   logic                        job_push, job_pop, job_empty;
   job_type                     job_new, job_head;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] job_count;
   logic [MJD_W-1:0]            mjd_bits;
   status_type                  status_out;

   assign accept = req_push && !req_full;

   // Front end: one parse step per accepted byte.
   dtm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .text_byte  (req_text_byte),
      .first_byte (req_first_byte),
      .job_push   (job_push),
      .job        (job_new)
   );

   // Queue of finished texts between the parser and the date math.
   dtm_queue #(
      .WIDTH ($bits(job_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_job_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .data_in  (job_new),
      .pop      (job_pop),
      .data_out (job_head),
      .full     (req_full),
      .empty    (job_empty),
      .count    (job_count)
   );

   // Back end: date checks, MJD arithmetic and the result queue.
   dtm_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!job_empty && (job_count != '0)),
      .job       (job_head),
      .job_pop   (job_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .mjd_value (mjd_bits),
      .status    (status_out)
   );

   assign rsp_mjd_value = $signed(mjd_bits);
   assign rsp_status    = status_out;

endmodule

// ----- design/dtm_checker.sv -----
`timescale 1ns / 1ps
// Port level checks for the date text to MJD parser core.
// Depends on dtm_pkg; bound to the top level at the end of this file.
module dtm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic [7:0]                        req_text_byte,
   input logic                              req_first_byte,
   input logic                              req_push,
   input logic                              req_full,
   input logic signed [dtm_pkg::MJD_W-1:0]  rsp_mjd_value,
   input logic [2:0]                        rsp_status,
   input logic                              rsp_empty,
   input logic                              rsp_pop
);

   import dtm_pkg::*;

   // Reset leaves no result waiting.
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> rsp_empty)
      else $error("result shown right after reset");

   // Only defined status codes come out.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_status <= ST_BIG_YEAR))
      else $error("undefined status code");

   // An error result carries a zero date.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != ST_OK) |-> (rsp_mjd_value == '0))
      else $error("error result with nonzero date");

   // A good date lies in the span of years 100 to 9999.
   a_mjd_range: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == ST_OK) |->
         (rsp_mjd_value >= -23'sd642417 && rsp_mjd_value <= 23'sd2973484))
      else $error("date out of range");

   // A waiting result stays put until popped.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_mjd_value) &&
                                    $stable(rsp_status)))
      else $error("waiting result changed");

endmodule

bind date_text_to_mjd_parser_core dtm_checker u_dtm_checker (.*);

// ----- verif/dtm_checker.sv -----
`timescale 1ns / 1ps
// Checker for the date text to MJD parser: watches both queue channels, predicts
// each result from the accepted request bytes and compares it field by field.
// Depends on dtm_pkg for field widths, character codes and status codes.
module dtm_tb_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [7:0]                        req_text_byte,
   input  logic                              req_first_byte,
   input  logic                              req_push,
   input  logic                              req_full,
   input  logic signed [dtm_pkg::MJD_W-1:0]  rsp_mjd_value,
   input  logic [2:0]                        rsp_status,
   input  logic                              rsp_empty,
   input  logic                              rsp_pop,
   output int                                fail_count,
   output int                                dates_due,
   output int                                bytes_taken,
   output int                                results_taken
);

   import dtm_pkg::*;

   typedef enum logic [2:0] {
      PS_IDLE,
      PS_SKIP,
      PS_YEAR,
      PS_MONTH,
      PS_DAY
   } parse_state_type;

   typedef struct {
      logic [MJD_W-1:0] mjd;
      status_type       status;
   } date_result_type;

   string month_names [12] = '{"JANUARY", "FEBRUARY", "MARCH", "APRIL", "MAY", "JUNE",
                               "JULY", "AUGUST", "SEPTEMBER", "OCTOBER", "NOVEMBER",
                               "DECEMBER"};
   int    days_in_month [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   // Predicted parser state.
   parse_state_type     parse_state;
   logic [YEAR_W-1:0]   year;
   logic                year_too_big;
   logic [CAND_W-1:0]   cands;
   logic [3:0]          letters;
   logic [DAY_W-1:0]    day;

   date_result_type     dates_expected [$];
   date_result_type     oldest;

   initial begin
      fail_count    = 0;
      dates_due     = 0;
      bytes_taken   = 0;
      results_taken = 0;
   end

   function automatic bit is_digit_char(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic bit is_letter_char(input logic [7:0] c);
      return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
   endfunction

   task automatic report_mismatch(input string what);
      fail_count++;
      $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   task automatic clear_fields();
      year         = '0;
      year_too_big = 1'b0;
      cands        = '1;
      letters      = '0;
      day          = '0;
   endtask

   // Queue a predicted result; any result ends the text.
   task automatic post_date(input int mjd, input status_type st);
      date_result_type entry;
      entry.mjd    = MJD_W'(mjd);
      entry.status = st;
      dates_expected.push_back(entry);
      parse_state = PS_IDLE;
   endtask

   // Drop every month whose name lacks this letter at the current position.
   task automatic narrow_months(input logic [7:0] c);
      logic [7:0] up;
      up = c & CASE_MASK;
      for (int m = 0; m < 12; m++) begin
         if (int'(letters) >= MONTH_NAME_MAX || int'(letters) >= month_names[m].len()
             || month_names[m][int'(letters)] != up)
            cands[m] = 1'b0;
      end
      if (letters != 4'd15)
         letters++;
   endtask

   // Resolve the month, check the day and work out the date.
   task automatic finish_date();
      int hits;
      int mon;
      int yr;
      int leap;
      int last_day;
      int doy;
      int y;
      hits = 0;
      mon  = 0;
      for (int m = 0; m < 12; m++) begin
         if (cands[m]) begin
            hits++;
            mon = m;
         end
      end
      yr = int'(year);
      if (yr < 50)
         yr += 2000;
      if (yr < 100)
         yr += 1900;
      leap     = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
      last_day = days_in_month[mon] + ((mon == int'(MON_FEB)) ? leap : 0);
      if (hits != 1) begin
         post_date(0, ST_BAD_MONTH);
      end else if (int'(day) > last_day) begin
         post_date(0, ST_BIG_DAY);
      end else begin
         doy = 0;
         for (int m = 0; m < mon; m++)
            doy += days_in_month[m];
         if (mon > int'(MON_FEB))
            doy += leap;
         y = yr - 1;
         post_date(y * 365 + y / 4 - y / 100 + y / 400 + doy + int'(day) - int'(MJD_OFFSET),
                   ST_OK);
      end
   endtask

   // Advance the predicted parser by one accepted byte.
   task automatic take_text_byte(input logic [7:0] c, input logic first);
      int v;
      if (first) begin
         clear_fields();
         parse_state = PS_SKIP;
      end
      case (parse_state)
         PS_SKIP: begin
            if (c == CH_NUL) begin
               post_date(0, ST_EMPTY);
            end else if (is_digit_char(c)) begin
               year        = YEAR_W'(c - CH_ZERO);
               parse_state = PS_YEAR;
            end else if (c != CH_SPACE && c != CH_TAB) begin
               post_date(0, ST_NO_YEAR);
            end
         end
         PS_YEAR: begin
            if (is_digit_char(c)) begin
               v = int'(year) * 10 + int'(c - CH_ZERO);
               if (v > int'(YEAR_MAX)) begin
                  v            = int'(YEAR_MAX);
                  year_too_big = 1'b1;
               end
               year = YEAR_W'(v);
            end else if (year_too_big) begin
               post_date(0, ST_BIG_YEAR);
            end else if (!is_letter_char(c)) begin
               post_date(0, ST_NO_MONTH);
            end else begin
               narrow_months(c);
               parse_state = PS_MONTH;
            end
         end
         PS_MONTH: begin
            if (is_letter_char(c)) begin
               narrow_months(c);
            end else if (is_digit_char(c)) begin
               day         = DAY_W'(c - CH_ZERO);
               parse_state = PS_DAY;
            end else begin
               finish_date();
            end
         end
         PS_DAY: begin
            if (is_digit_char(c)) begin
               v   = int'(day) * 10 + int'(c - CH_ZERO);
               day = (v > int'(DAY_MAX)) ? DAY_MAX : DAY_W'(v);
            end else begin
               finish_date();
            end
         end
         default: begin
         end
      endcase
   endtask

   // Check popped results first, then predict from the accepted request.
   always @(posedge clock) begin
      if (reset) begin
         clear_fields();
         parse_state = PS_IDLE;
         dates_expected.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            results_taken++;
            if (dates_expected.size() == 0) begin
               report_mismatch($sformatf("result mjd %0d status %0d with no date pending",
                                         rsp_mjd_value, rsp_status));
            end else begin
               oldest = dates_expected.pop_front();
               if (rsp_status !== oldest.status)
                  report_mismatch($sformatf("status %0d, predicted %0d",
                                            rsp_status, oldest.status));
               if (rsp_mjd_value !== oldest.mjd)
                  report_mismatch($sformatf("mjd %0d, predicted %0d",
                                            rsp_mjd_value, $signed(oldest.mjd)));
            end
         end
         if (req_push && !req_full) begin
            bytes_taken++;
            take_text_byte(req_text_byte, req_first_byte);
         end
      end
      dates_due <= dates_expected.size();
   end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Top of the date parser testbench: clock, reset, request stimulus and verdict.
// Depends on dtm_pkg, date_text_to_mjd_parser_core and dtm_tb_checker.
module testbench;
   import dtm_pkg::*;

   localparam int CLOCK_LIMIT            = 200000;
   localparam int RANDOM_BYTES_PER_PHASE = 70;

   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic [7:0]               req_text_byte  = '0;
   logic                     req_first_byte = 1'b0;
   logic                     req_push       = 1'b0;
   logic                     req_full;
   logic signed [MJD_W-1:0]  rsp_mjd_value;
   logic [2:0]               rsp_status;
   logic                     rsp_empty;
   logic                     rsp_pop        = 1'b0;

   int fail_count;
   int dates_due;
   int bytes_taken;
   int results_taken;

   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   int cycle_count   = 0;
   int texts_sent    = 0;
   int bytes_sent    = 0;

   // Text under construction: one first-byte flag per byte.
   logic [7:0] text_bytes [$];
   logic       text_firsts [$];

   string month_names [12] = '{"JANUARY", "FEBRUARY", "MARCH", "APRIL", "MAY", "JUNE",
                               "JULY", "AUGUST", "SEPTEMBER", "OCTOBER", "NOVEMBER",
                               "DECEMBER"};

   date_text_to_mjd_parser_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_text_byte  (req_text_byte),
      .req_first_byte (req_first_byte),
      .req_push       (req_push),
      .req_full       (req_full),
      .rsp_mjd_value  (rsp_mjd_value),
      .rsp_status     (rsp_status),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop)
   );

   dtm_tb_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_text_byte  (req_text_byte),
      .req_first_byte (req_first_byte),
      .req_push       (req_push),
      .req_full       (req_full),
      .rsp_mjd_value  (rsp_mjd_value),
      .rsp_status     (rsp_status),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .fail_count     (fail_count),
      .dates_due      (dates_due),
      .bytes_taken    (bytes_taken),
      .results_taken  (results_taken)
   );

   always #5 clock = ~clock;

   // Receiver: pops at random according to the current stall rate.
   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CLOCK_LIMIT) begin
         $display("Timeout after %0d cycles with %0d dates still due", cycle_count, dates_due);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Send one request byte, idling first at the current rate, and wait for it to be taken.
   task automatic send_byte(input logic [7:0] b, input logic first);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < send_idle_pct);
      end
      req_text_byte  <= b;
      req_first_byte <= first;
      req_push       <= 1'b1;
      do
         @(posedge clock);
      while (req_full);
      bytes_sent++;
   endtask

   task automatic send_text();
      texts_sent++;
      foreach (text_bytes[i])
         send_byte(text_bytes[i], text_firsts[i]);
   endtask

   task automatic add_char(input logic [7:0] c);
      text_firsts.push_back(text_bytes.size() == 0);
      text_bytes.push_back(c);
   endtask

   task automatic send_str(input string body, input logic [7:0] term, input bit terminated = 1);
      text_bytes.delete();
      text_firsts.delete();
      for (int i = 0; i < body.len(); i++)
         add_char(body[i]);
      if (terminated)
         add_char(term);
      send_text();
   endtask

   function automatic logic [7:0] random_case(input logic [7:0] c);
      return $urandom_range(1) ? (c | ~CASE_MASK) : c;
   endfunction

   // Any byte that is neither a digit nor a letter ends a text.
   function automatic logic [7:0] random_stop_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(255));
      while ((b >= CH_ZERO && b <= CH_NINE)
             || ((b & CASE_MASK) >= CH_UP_A && (b & CASE_MASK) <= CH_UP_Z));
      return b;
   endfunction

   task automatic run_directed_texts();
      // A byte with no text in progress is ignored.
      send_byte(8'hA5, 1'b0);
      send_str("", CH_NUL);
      send_str(" \t", "x");
      send_str("9", "-");
      // A year above 9999 is flagged at the first byte after the digits.
      send_str("12345", "m");
      send_str("00feB29", CH_NUL);
      send_str("1900FEB29", CH_SPACE);
      // Two months share this prefix.
      send_str("99ju", CH_NUL);
      // The day counter saturates and is always too big.
      send_str("7d99999", 8'hFF);
      // Left unfinished: the next text drops it.
      send_str("85ma", CH_NUL, 1'b0);
      send_str("49Dec", "/");
      send_str("50jan0", CH_NUL);
      send_str("9999december31", CH_NUL);
      // More letters than any name, enough to saturate the letter count.
      send_str("0januaryjanuaryjan", CH_NUL);
      send_str("100September30", 8'h7F);
   endtask

   // Mostly well-formed dates with random content, some broken ones and some noise.
   task automatic build_random_text();
      int    kind;
      int    mon;
      int    n;
      int    value;
      string name;
      text_bytes.delete();
      text_firsts.delete();
      kind = $urandom_range(99);
      if (kind < 8) begin
         // Noise: random bytes, each of which may start a new text.
         n = $urandom_range(1, 6);
         repeat (n) begin
            text_bytes.push_back(8'($urandom_range(255)));
            text_firsts.push_back(1'($urandom_range(1)));
         end
      end else begin
         if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) add_char($urandom_range(1) ? CH_SPACE : CH_TAB);
         // Year digits; a few texts have none or too many.
         n = (kind < 11) ? 0 : (kind < 16) ? $urandom_range(5, 6) : $urandom_range(1, 4);
         repeat (n) add_char(CH_ZERO + 8'($urandom_range(9)));
         if (kind >= 19) begin
            // Month name prefix in mixed case, now and then with stray letters.
            mon  = $urandom_range(11);
            name = month_names[mon];
            n    = ($urandom_range(3) == 0) ? $urandom_range(1, name.len())
                                            : $urandom_range(3, name.len());
            for (int i = 0; i < n; i++)
               add_char(random_case(name[i]));
            if ($urandom_range(7) == 0)
               repeat ($urandom_range(1, 3))
                  add_char(random_case(CH_UP_A + 8'($urandom_range(25))));
            // Day: none, a plausible one, or random digits.
            case ($urandom_range(3))
               0: begin
               end
               1, 2: begin
                  value = $urandom_range(1, 31);
                  if (value >= 10 || $urandom_range(1))
                     add_char(CH_ZERO + 8'(value / 10));
                  add_char(CH_ZERO + 8'(value % 10));
               end
               default: begin
                  repeat ($urandom_range(1, 4)) add_char(CH_ZERO + 8'($urandom_range(9)));
               end
            endcase
         end
         // End with NUL, with any other stop byte, or not at all.
         case ($urandom_range(4))
            0, 1:    add_char(CH_NUL);
            2, 3:    add_char(random_stop_byte());
            default: begin
            end
         endcase
      end
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (dates_due != 0)
         @(posedge clock);
   endtask

   // Stimulus: reset, then four idle and stall patterns, draining after each.
   initial begin
      int phase_start;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int phase_idx = 0; phase_idx < 4; phase_idx++) begin
         case (phase_idx)
            0: begin
               send_idle_pct = 0;
               pop_stall_pct <= 0;
            end
            1: begin
               send_idle_pct = 62;
               pop_stall_pct <= 0;
            end
            2: begin
               send_idle_pct = 0;
               pop_stall_pct <= 62;
            end
            default: begin
               send_idle_pct = 10;
               pop_stall_pct <= 10;
            end
         endcase
         if (phase_idx == 0)
            run_directed_texts();
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < RANDOM_BYTES_PER_PHASE) begin
            build_random_text();
            send_text();
         end
         // Hold off until every pending date has come back.
         req_push <= 1'b0;
         wait_drained();
      end
      repeat (20) @(posedge clock);
      $display("Ran %0d texts as %0d request bytes under four idle and stall patterns,",
               texts_sent, bytes_taken);
      $display("and checked %0d results against the predicted dates and status codes.",
               results_taken);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
